### rtl/keyword_mask_line_macros.svh
// Assertion helpers shared by the keyword mask line modules.
// Both forms assume a clock named clk and an active-low reset named arst_n.
`ifndef KEYWORD_MASK_LINE_MACROS_SVH
`define KEYWORD_MASK_LINE_MACROS_SVH
`ifndef SYNTHESIS
`define KML_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KML_NEVER(lbl, cond, msg) \
	`KML_ASSERT(lbl, !(cond), msg)
`else
`define KML_ASSERT(lbl, prop, msg)
`define KML_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/kml_pkg.sv
`timescale 1ns / 1ps
package kml_pkg;

	// Operation codes on the input port.
	localparam logic [2:0] OP_LOAD_CHAR = 3'd0;
	localparam logic [2:0] OP_SET_LEN   = 3'd1;
	localparam logic [2:0] OP_TEXT      = 3'd2;
	localparam logic [2:0] OP_READ_CNT  = 3'd3;
	localparam logic [2:0] OP_CLEAR     = 3'd4;

	// Result kinds.
	localparam logic KIND_TEXT  = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	localparam logic [15:0] MASK_UNIT = 16'h002A;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Entries in the command queue between front and back.
	localparam int CMDQ_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_WCHAR = 3'd0,
		CMD_WLEN  = 3'd1,
		CMD_TEXT  = 3'd2,
		CMD_READ  = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        word_ok;
		logic        char_ok;
		logic [4:0]  word_index;
		logic [3:0]  char_index;
		logic [15:0] code_unit;
		logic [4:0]  word_length;
		logic        line_end;
	} cmd_t;

	// Lower-case folding of a text unit before it is compared.
	function automatic logic [15:0] fold_unit(input logic [15:0] u);
		logic [15:0] r;
		r = u;
		if (u >= 16'h0041 && u <= 16'h005A) begin
			r = u + 16'h0020;
		end else if (u >= 16'h00C0 && u <= 16'h00DE && u != 16'h00D7) begin
			r = u + 16'h0020;
		end else if (u >= 16'h0410 && u <= 16'h042F) begin
			r = u + 16'h0020;
		end else if (u >= 16'h0400 && u <= 16'h040F) begin
			r = u + 16'h0050;
		end
		return r;
	endfunction

endpackage

### rtl/keyword_mask_line.sv
`timescale 1ns / 1ps
// Banned-word masking of one buffered text line. Load word units (operation 0) and
// word lengths (operation 1), set active_words, then push text units (operation 2).
// When a unit carries line_end, or LINE_DEPTH units are buffered, the line is scanned
// left to right; at each position the lowest-index active word that equals the
// case-folded text wins, its units become '*', its hit counter is bumped (saturating
// at 65535) and the scan moves past it. The line then comes out one unit per item,
// with last on the final unit and line_replaced set if anything was masked.
// Operation 3 returns one hit count item; operation 4 clears all counts.
// The execution sequencer takes queued operations one at a time while idle. A flush
// walks each scan position through S_WORD for each word checked, then for each
// compared unit through a registered read of the word table and line buffer (S_RD)
// and a compare (S_CMP); a position with no matching word is left from S_WORD, and
// a match writes '*' to each of its units in S_MASK. S_WORD closes the scan; each
// emitted unit is read (S_ERD), then offered to the result register (S_EOUT). The
// word table and line buffer each have one read port. A two-entry command queue keeps
// taking input while the scan runs, and the single result register lets a finished
// item wait for pop without stopping the sequencer until the next result is ready.
module keyword_mask_line import kml_pkg::*; #(
	parameter int MAX_WORDS    = 32,
	parameter int MAX_WORD_LEN = 16,
	parameter int LINE_DEPTH   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        active_words_we,
	input  logic [5:0]  active_words,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  operation,
	input  logic [4:0]  word_index,
	input  logic [3:0]  char_index,
	input  logic [15:0] code_unit,
	input  logic [4:0]  word_length,
	input  logic        line_end,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [15:0] out_unit,
	output logic        last,
	output logic        line_replaced,
	output logic [15:0] hit_count
);

	logic q_full;
	logic q_push;
	cmd_t q_din;
	logic q_empty;
	logic q_pop;
	cmd_t q_dout;
	logic out_valid;

	// Front: decode and index checks.
	kml_front #(
		.MAX_WORDS   (MAX_WORDS),
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_front (
		.push       (push),
		.full       (full),
		.operation  (operation),
		.word_index (word_index),
		.char_index (char_index),
		.code_unit  (code_unit),
		.word_length(word_length),
		.line_end   (line_end),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_din)
	);

	// Decoupling queue between the front and the execution sequencer.
	kml_cmdq u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	// Back: table stores, line buffer, scan and emit.
	kml_back #(
		.MAX_WORDS   (MAX_WORDS),
		.MAX_WORD_LEN(MAX_WORD_LEN),
		.LINE_DEPTH  (LINE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (active_words_we),
		.cfg_data    (active_words),
		.q_empty     (q_empty),
		.q_cmd       (q_dout),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_pop     (pop),
		.out_kind    (kind),
		.out_unit    (out_unit),
		.out_last    (last),
		.out_replaced(line_replaced),
		.out_count   (hit_count)
	);

	assign empty = !out_valid;

endmodule

### rtl/kml_front.sv
`timescale 1ns / 1ps
module kml_front import kml_pkg::*; #(
	parameter int MAX_WORDS    = 32,
	parameter int MAX_WORD_LEN = 16
) (
	input  logic        push,
	output logic        full,
	input  logic [2:0]  operation,
	input  logic [4:0]  word_index,
	input  logic [3:0]  char_index,
	input  logic [15:0] code_unit,
	input  logic [4:0]  word_length,
	input  logic        line_end,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic op_known;

	// Decode the operation and check the table indexes once, here.
	always_comb begin
		q_cmd             = '0;
		q_cmd.word_ok     = int'(word_index) < MAX_WORDS;
		q_cmd.char_ok     = int'(char_index) < MAX_WORD_LEN;
		q_cmd.word_index  = word_index;
		q_cmd.char_index  = char_index;
		q_cmd.code_unit   = code_unit;
		q_cmd.word_length = word_length;
		q_cmd.line_end    = line_end;
		op_known          = 1'b1;
		case (operation)
			OP_LOAD_CHAR: q_cmd.kind = CMD_WCHAR;
			OP_SET_LEN:   q_cmd.kind = CMD_WLEN;
			OP_TEXT:      q_cmd.kind = CMD_TEXT;
			OP_READ_CNT:  q_cmd.kind = CMD_READ;
			OP_CLEAR:     q_cmd.kind = CMD_CLEAR;
			default: begin
				q_cmd.kind = CMD_WCHAR;
				op_known   = 1'b0;
			end
		endcase
	end

	// Unknown operations are taken and dropped.
	assign full   = q_full;
	assign q_push = push && !q_full && op_known;

endmodule

### rtl/kml_cmdq.sv
`timescale 1ns / 1ps
`include "keyword_mask_line_macros.svh"
module kml_cmdq import kml_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	localparam int PTRW = $clog2(CMDQ_DEPTH);
	localparam int CNTW = $clog2(CMDQ_DEPTH + 1);

	cmd_t            mem_q [CMDQ_DEPTH];
	logic [PTRW-1:0] wptr_q;
	logic [PTRW-1:0] rptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == CNTW'(CMDQ_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (int'(wptr_q) == CMDQ_DEPTH - 1) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (int'(rptr_q) == CMDQ_DEPTH - 1) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`KML_NEVER(a_cmdq_overfill, count_q > CNTW'(CMDQ_DEPTH), "command queue overfilled")
	`KML_NEVER(a_cmdq_push_full, push && full, "push into a full command queue")

endmodule

### rtl/kml_back.sv
`timescale 1ns / 1ps
`include "keyword_mask_line_macros.svh"
module kml_back import kml_pkg::*; #(
	parameter int MAX_WORDS    = 32,
	parameter int MAX_WORD_LEN = 16,
	parameter int LINE_DEPTH   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_data,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_pop,
	output logic        out_kind,
	output logic [15:0] out_unit,
	output logic        out_last,
	output logic        out_replaced,
	output logic [15:0] out_count
);

	localparam int WA = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WC = $clog2(MAX_WORDS + 1);
	localparam int JW = $clog2(MAX_WORD_LEN);
	localparam int LW = $clog2(MAX_WORD_LEN + 1);
	localparam int SD = MAX_WORDS * MAX_WORD_LEN;
	localparam int SA = $clog2(SD);
	localparam int LA = $clog2(LINE_DEPTH);
	localparam int PW = $clog2(LINE_DEPTH + 1);
	localparam int SW = ((PW > LW) ? PW : LW) + 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_WORD = 7'b0000010,
		S_RD   = 7'b0000100,
		S_CMP  = 7'b0001000,
		S_MASK = 7'b0010000,
		S_ERD  = 7'b0100000,
		S_EOUT = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [5:0]      active_q;
	logic [PW-1:0]   fill_q;
	logic [PW-1:0]   pos_q;
	logic [WC-1:0]   w_q;
	logic [LW-1:0]   j_q;
	logic [LW-1:0]   len_q;
	logic [PW-1:0]   e_q;
	logic            repl_q;
	logic [LW-1:0]   wlen_q [MAX_WORDS];
	logic [15:0]     cnt_q [MAX_WORDS];
	logic [15:0]     word_mem [SD];
	logic [15:0]     line_mem [LINE_DEPTH];
	logic [15:0]     wrd_rd_q;
	logic [15:0]     line_rd_q;

	logic            out_valid_q;
	logic            kind_q;
	logic [15:0]     unit_q;
	logic            last_q;
	logic            orepl_q;
	logic [15:0]     ocnt_q;

	logic [WC-1:0]   nact;
	logic [15:0]     wi_ext;
	logic [15:0]     ci_ext;
	logic [WA-1:0]   head_w;
	logic [WA-1:0]   scan_w;
	logic [LW-1:0]   cur_len;
	logic [SW-1:0]   word_end;
	logic            fits;
	logic            out_free;
	logic            word_match;
	logic            last_char;
	logic [SA-1:0]   wr_addr;
	logic [SA-1:0]   rd_addr;
	logic [LA-1:0]   scan_addr;
	logic            line_we;
	logic [LA-1:0]   line_waddr;
	logic [15:0]     line_wdata;
	logic            line_re;
	logic [LA-1:0]   line_raddr;
	logic [LW-1:0]   sat_len;
	logic            text_flush;

	assign nact = (int'(active_q) > MAX_WORDS) ? WC'(MAX_WORDS) : WC'(active_q);
	assign wi_ext = 16'(q_cmd.word_index);
	assign ci_ext = 16'(q_cmd.char_index);
	assign head_w = wi_ext[WA-1:0];
	assign scan_w = w_q[WA-1:0];
	assign cur_len = wlen_q[scan_w];
	assign word_end = SW'(pos_q) + SW'(cur_len);
	assign fits = word_end <= SW'(fill_q);
	assign out_free = !out_valid_q || out_pop;
	assign word_match = wrd_rd_q == fold_unit(line_rd_q);
	assign last_char = j_q == len_q - 1'b1;
	assign sat_len = (int'(q_cmd.word_length) > MAX_WORD_LEN) ? LW'(MAX_WORD_LEN)
		: LW'(q_cmd.word_length);
	assign text_flush = q_cmd.line_end || (int'(fill_q) + 1 >= LINE_DEPTH);

	assign wr_addr = SA'(head_w) * SA'(MAX_WORD_LEN) + SA'(ci_ext[JW-1:0]);
	assign rd_addr = SA'(scan_w) * SA'(MAX_WORD_LEN) + SA'(j_q);
	assign scan_addr = LA'(SW'(pos_q) + SW'(j_q));

	// A read of the head command also waits for a free result slot.
	assign q_pop = (state_q == S_IDLE) && !q_empty
		&& (q_cmd.kind != CMD_READ || out_free);

	// Line buffer port muxing: text fill and masking write, scan and emit read.
	always_comb begin
		line_we    = 1'b0;
		line_waddr = scan_addr;
		line_wdata = MASK_UNIT;
		if (q_pop && q_cmd.kind == CMD_TEXT) begin
			line_we    = 1'b1;
			line_waddr = fill_q[LA-1:0];
			line_wdata = q_cmd.code_unit;
		end else if (state_q == S_MASK) begin
			line_we = 1'b1;
		end
		line_re    = (state_q == S_RD) || (state_q == S_ERD);
		line_raddr = (state_q == S_ERD) ? e_q[LA-1:0] : scan_addr;
	end

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_waddr] <= line_wdata;
		end
		if (line_re) begin
			line_rd_q <= line_mem[line_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == CMD_WCHAR && q_cmd.word_ok && q_cmd.char_ok) begin
			word_mem[wr_addr] <= q_cmd.code_unit;
		end
		if (state_q == S_RD) begin
			wrd_rd_q <= word_mem[rd_addr];
		end
	end

	// Table lengths and hit counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WORDS; i++) begin
				wlen_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (q_pop && q_cmd.kind == CMD_WLEN && q_cmd.word_ok) begin
				wlen_q[head_w] <= sat_len;
			end
			if (q_pop && q_cmd.kind == CMD_CLEAR) begin
				for (int i = 0; i < MAX_WORDS; i++) begin
					cnt_q[i] <= '0;
				end
			end else if (state_q == S_CMP && word_match && last_char
				&& cnt_q[scan_w] != COUNT_MAX) begin
				cnt_q[scan_w] <= cnt_q[scan_w] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	// Scan sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			pos_q   <= '0;
			w_q     <= '0;
			j_q     <= '0;
			len_q   <= '0;
			e_q     <= '0;
			repl_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_pop && q_cmd.kind == CMD_TEXT) begin
						fill_q <= fill_q + 1'b1;
						if (text_flush) begin
							pos_q   <= '0;
							w_q     <= '0;
							repl_q  <= 1'b0;
							state_q <= S_WORD;
						end
					end
				end
				S_WORD: begin
					if (pos_q >= fill_q) begin
						e_q     <= '0;
						state_q <= S_ERD;
					end else if (w_q >= nact) begin
						pos_q <= pos_q + 1'b1;
						w_q   <= '0;
					end else if (cur_len == '0 || !fits) begin
						w_q <= w_q + 1'b1;
					end else begin
						len_q   <= cur_len;
						j_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!word_match) begin
						w_q     <= w_q + 1'b1;
						state_q <= S_WORD;
					end else if (last_char) begin
						repl_q  <= 1'b1;
						j_q     <= '0;
						state_q <= S_MASK;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_MASK: begin
					if (last_char) begin
						pos_q   <= PW'(SW'(pos_q) + SW'(len_q));
						w_q     <= '0;
						state_q <= S_WORD;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (out_free) begin
						e_q <= e_q + 1'b1;
						if (e_q + 1'b1 == fill_q) begin
							fill_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EOUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (q_pop && q_cmd.kind == CMD_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EOUT && out_free) begin
			kind_q  <= KIND_TEXT;
			unit_q  <= line_rd_q;
			last_q  <= e_q + 1'b1 == fill_q;
			orepl_q <= repl_q;
			ocnt_q  <= '0;
		end else if (q_pop && q_cmd.kind == CMD_READ) begin
			kind_q  <= KIND_COUNT;
			unit_q  <= '0;
			last_q  <= 1'b0;
			orepl_q <= 1'b0;
			ocnt_q  <= q_cmd.word_ok ? cnt_q[head_w] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_q;
	assign out_unit     = unit_q;
	assign out_last     = last_q;
	assign out_replaced = orepl_q;
	assign out_count    = ocnt_q;

	`KML_NEVER(a_fill_range, int'(fill_q) > LINE_DEPTH, "line fill beyond buffer depth")
	`KML_NEVER(a_mask_inside, (state_q == S_MASK) && (SW'(pos_q) + SW'(j_q) >= SW'(fill_q)), "masking outside the buffered line")
	`KML_ASSERT(a_hit_marks_line, (state_q == S_MASK) |-> repl_q, "hit without line flag")

endmodule
